FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl of the quaternion to euler block
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// cond must hold at every clock edge outside reset
`define QTE_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
// cons must hold whenever ante holds
`define QTE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define QTE_ASSERT_ALWAYS(label, clk, rst, cond)
`define QTE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/qte_pkg.sv
// constants, types and the arctangent table of the quaternion to euler block
// no dependencies
package qte_pkg;

   localparam int PROD_FRAC = 28;
   localparam int ANG_W = 28;
   localparam int ATAN_LEN = 24;
   localparam int ANGLE_W = 16;
   localparam int PITCH_W = 15;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q24 = 28'sd26353589;
   localparam logic signed [ANGLE_W-1:0] PI_Q13 = 16'sd25736;
   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q13 = 16'sd12868;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] yaw;
      logic signed [PITCH_W-1:0] pitch;
      logic signed [ANGLE_W-1:0] roll;
      logic                      sat;
   } rsp_type;

   // atan(2^-i) in q.24
   function automatic logic signed [ANG_W-1:0] atan_q24(input int i);
      logic signed [ANG_W-1:0] v;
      case (i)
         0: v = 28'sd13176795;
         1: v = 28'sd7778716;
         2: v = 28'sd4110060;
         3: v = 28'sd2086331;
         4: v = 28'sd1047214;
         5: v = 28'sd524117;
         6: v = 28'sd262123;
         7: v = 28'sd131069;
         8: v = 28'sd65536;
         9: v = 28'sd32768;
         10: v = 28'sd16384;
         11: v = 28'sd8192;
         12: v = 28'sd4096;
         13: v = 28'sd2048;
         14: v = 28'sd1024;
         15: v = 28'sd512;
         16: v = 28'sd256;
         17: v = 28'sd128;
         18: v = 28'sd64;
         19: v = 28'sd32;
         20: v = 28'sd16;
         21: v = 28'sd8;
         22: v = 28'sd4;
         23: v = 28'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: hw/rtl/qte_sqrt.sv
// pipelined integer square root, one root bit per stage, floor result
// depends on nothing but its parameter
module qte_sqrt #(
   parameter int ROOT_W = 15
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [2*ROOT_W-2:0]   rad,
   output logic [ROOT_W-1:0]     root
);
   localparam int RW = 2 * ROOT_W - 1;
   localparam int TW = RW + 1;

   logic [RW-1:0]     rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0] root_ff [0:ROOT_W];

   assign rem_ff[0] = rad;
   assign root_ff[0] = '0;

   // stage k decides root bit ROOT_W-1-k
   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;
      logic [TW-1:0]     trial;
      logic [RW-1:0]     rem_in;
      logic [ROOT_W-1:0] root_in;

      always_comb begin
         trial = (TW'(root_ff[k]) << (B + 1)) + (TW'(1) << (2 * B));
         if (TW'(rem_ff[k]) >= trial) begin
            rem_in = RW'(TW'(rem_ff[k]) - trial);
            root_in = root_ff[k] | (ROOT_W'(1) << B);
         end else begin
            rem_in = rem_ff[k];
            root_in = root_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= rem_in;
            root_ff[k+1] <= root_in;
         end
      end
   end

   assign root = root_ff[ROOT_W];

endmodule

FILE: hw/rtl/qte_cordic.sv
// pipelined cordic in vectoring mode: atan2(y, x) in q3.13, clamped to +-pi
// depends on qte_pkg for the angle table
module qte_cordic #(
   parameter int DW = 22,
   parameter int STAGES = 16
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [DW-1:0]                x,
   input  logic signed [DW-1:0]                y,
   output logic signed [qte_pkg::ANGLE_W-1:0]  angle
);
   import qte_pkg::*;

   localparam int N = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;
   localparam int QW = ANG_W - 11;

   logic signed [DW-1:0]    x_ff [0:N];
   logic signed [DW-1:0]    y_ff [0:N];
   logic signed [ANG_W-1:0] z_ff [0:N];
   logic                    zero_ff [0:N];
   logic signed [ANGLE_W-1:0] angle_ff;

   // quadrant turn for left half plane, zero vector flag
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (x == '0) && (y == '0);
         if (x < 0) begin
            if (y >= 0) begin
               x_ff[0] <= y;
               y_ff[0] <= -x;
               z_ff[0] <= HALF_PI_Q24;
            end else begin
               x_ff[0] <= -y;
               y_ff[0] <= x;
               z_ff[0] <= -HALF_PI_Q24;
            end
         end else begin
            x_ff[0] <= x;
            y_ff[0] <= y;
            z_ff[0] <= '0;
         end
      end
   end

   // one micro rotation per stage
   for (genvar i = 0; i < N; i++) begin : g_iter
      localparam logic signed [ANG_W-1:0] ANG = atan_q24(i);
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ANG;
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ANG;
            end
         end
      end
   end

   // round q.24 to q3.13 and clamp
   logic signed [ANG_W-1:0] z_rnd;
   logic signed [QW-1:0]    q;
   logic signed [ANGLE_W-1:0] angle_in;

   always_comb begin
      z_rnd = z_ff[N] + ANG_W'(1024);
      q = QW'(z_rnd >>> 11);
      if (zero_ff[N]) begin
         angle_in = '0;
      end else if (q > QW'(PI_Q13)) begin
         angle_in = PI_Q13;
      end else if (q < -QW'(PI_Q13)) begin
         angle_in = -PI_Q13;
      end else begin
         angle_in = ANGLE_W'(q);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

FILE: hw/rtl/quaternion_to_euler_zyx.sv
// top level: quaternion (q1.14) to zyx euler angles (q3.13), fully pipelined
// depends on qte_pkg, qte_sqrt, qte_cordic and assert_macros.svh
//
// usage
//   req channel carries one quaternion per item: qx, qy, qz, qw packed in
//   req_tdata from the low bits up. rsp channel carries roll, pitch and yaw in
//   rsp_tdata and the pitch clamp flag in rsp_tuser, exactly one rsp item per
//   req item, in order.
//   throughput is one item per cycle unless a stalled rsp side fills the skid
//   register. from req acceptance to rsp_tvalid an item passes five stages of
//   products, sums, rounding, square and radicand, COMP_FRAC_BITS + 1 stages
//   of the bit-per-stage square root on the pitch path, the cordic stages plus
//   quadrant turn and rounding, the pitch clamp stage and the output register.
//   a stalled rsp side parks one item in a skid register; req_tready is
//   registered and drops only when the skid register is full, which also
//   freezes every pipeline stage, so nothing is lost or repeated.
//   reset clears all valid bits and the skid; datapath registers are not reset.
module quaternion_to_euler_zyx #(
   parameter int CORDIC_STAGES = 16,
   parameter int COMP_FRAC_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // qx[15:0], qy[31:16], qz[47:32], qw[63:48]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // roll[15:0], pitch[30:16], yaw[46:31], zero[47]
   output logic        rsp_tuser   // pitch_saturated[0]
);
   import qte_pkg::*;

`include "assert_macros.svh"

   localparam int CF = COMP_FRAC_BITS;
   localparam int CW = CF + 7;
   localparam int DW = CF + 8;
   localparam int ROOT_W = CF + 1;
   localparam int N = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
   localparam int CL = N + 2;
   localparam int DL = ROOT_W + 2;
   localparam int DS = DL + CL;
   localparam int VL = DS + 4;
   localparam int SW = 34;

   logic en;
   logic skid_vld_ff;
   logic out_vld_ff;
   logic [VL-1:0] vld_ff;

   assign en = ~skid_vld_ff;
   assign req_tready = ~skid_vld_ff;

   // valid bits travel with the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[VL-2:0], req_tvalid};
      end
   end

   // stage 1: products
   logic signed [15:0] qx, qy, qz, qw;
   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;

   assign qx = req_tdata[15:0];
   assign qy = req_tdata[31:16];
   assign qz = req_tdata[47:32];
   assign qw = req_tdata[63:48];

   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= qw * qx;
         yz_ff <= qy * qz;
         xx_ff <= qx * qx;
         yy_ff <= qy * qy;
         wy_ff <= qw * qy;
         zx_ff <= qz * qx;
         wz_ff <= qw * qz;
         xy_ff <= qx * qy;
         zz_ff <= qz * qz;
      end
   end

   // stage 2: sine and cosine terms in q.28
   localparam logic signed [SW-1:0] ONE28 = SW'(64'sd1 <<< PROD_FRAC);
   logic signed [SW-1:0] sr_ff, cr_ff, sp_ff, sy_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff <= (SW'(wx_ff) + SW'(yz_ff)) <<< 1;
         cr_ff <= ONE28 - ((SW'(xx_ff) + SW'(yy_ff)) <<< 1);
         sp_ff <= (SW'(wy_ff) - SW'(zx_ff)) <<< 1;
         sy_ff <= (SW'(wz_ff) + SW'(xy_ff)) <<< 1;
         cy_ff <= ONE28 - ((SW'(yy_ff) + SW'(zz_ff)) <<< 1);
      end
   end

   // stage 3: round to working fraction, pitch clamp test
   logic signed [SW-1:0] term [0:4];
   logic signed [CW-1:0] comp [0:4];
   logic signed [CW-1:0] comp_ff [0:4];
   logic sat_ff, sat_pos_ff;

   assign term[0] = sr_ff;
   assign term[1] = cr_ff;
   assign term[2] = sy_ff;
   assign term[3] = cy_ff;
   assign term[4] = sp_ff;

   for (genvar j = 0; j < 5; j++) begin : g_comp
      if (CF >= PROD_FRAC) begin : g_up
         assign comp[j] = CW'(term[j]) <<< (CF - PROD_FRAC);
      end else begin : g_down
         localparam int SH = PROD_FRAC - CF;
         logic signed [SW-1:0] biased;
         assign biased = term[j] + (SW'(1) <<< (SH - 1));
         assign comp[j] = CW'(biased >>> SH);
      end
      always_ff @(posedge clock) begin
         if (en) begin
            comp_ff[j] <= comp[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff <= (sp_ff >= ONE28) || (sp_ff <= -ONE28);
         sat_pos_ff <= sp_ff > 0;
      end
   end

   // stage 4: square of pitch sine
   logic signed [CW-1:0] s_abs;
   logic [ROOT_W-1:0] mag;
   logic [2*ROOT_W-1:0] sq_ff;

   assign s_abs = (comp_ff[4] < 0) ? -comp_ff[4] : comp_ff[4];
   assign mag = s_abs[ROOT_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= mag * mag;
      end
   end

   // stage 5: radicand 1 - s^2, floored at zero
   localparam logic [2*ROOT_W-1:0] FULL = (2*ROOT_W)'(1) << (2 * CF);
   logic [2*ROOT_W-2:0] rad_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff <= (sq_ff >= FULL) ? '0 : (2*ROOT_W-1)'(FULL - sq_ff);
      end
   end

   logic [ROOT_W-1:0] root;

   qte_sqrt #(
      .ROOT_W (ROOT_W)
   ) u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (rad_ff),
      .root  (root)
   );

   // align atan2 operands with the square root output
   logic signed [CW-1:0] dly_ff [0:DL-1][0:4];

   for (genvar d = 0; d < DL; d++) begin : g_dly
      for (genvar j = 0; j < 5; j++) begin : g_lane
         always_ff @(posedge clock) begin
            if (en) begin
               dly_ff[d][j] <= (d == 0) ? comp_ff[j] : dly_ff[(d == 0) ? 0 : d-1][j];
            end
         end
      end
   end

   // clamp flag and its sign ride alongside to the cordic outputs
   logic [1:0] sat_dly_ff [0:DS-1];

   for (genvar d = 0; d < DS; d++) begin : g_sat
      always_ff @(posedge clock) begin
         if (en) begin
            sat_dly_ff[d] <= (d == 0) ? {sat_pos_ff, sat_ff} : sat_dly_ff[(d == 0) ? 0 : d-1];
         end
      end
   end

   logic signed [ANGLE_W-1:0] roll_a, yaw_a, pitch_a;

   qte_cordic #(
      .DW     (DW),
      .STAGES (CORDIC_STAGES)
   ) u_roll (
      .clock (clock),
      .en    (en),
      .x     (DW'(dly_ff[DL-1][1])),
      .y     (DW'(dly_ff[DL-1][0])),
      .angle (roll_a)
   );

   qte_cordic #(
      .DW     (DW),
      .STAGES (CORDIC_STAGES)
   ) u_yaw (
      .clock (clock),
      .en    (en),
      .x     (DW'(dly_ff[DL-1][3])),
      .y     (DW'(dly_ff[DL-1][2])),
      .angle (yaw_a)
   );

   qte_cordic #(
      .DW     (DW),
      .STAGES (CORDIC_STAGES)
   ) u_pitch (
      .clock (clock),
      .en    (en),
      .x     (DW'(signed'({1'b0, root}))),
      .y     (DW'(dly_ff[DL-1][4])),
      .angle (pitch_a)
   );

   // final stage: pitch clamp and saturation select
   rsp_type fin_ff, fin_in;

   always_comb begin
      fin_in.roll = roll_a;
      fin_in.yaw = yaw_a;
      fin_in.sat = sat_dly_ff[DS-1][0];
      if (sat_dly_ff[DS-1][0]) begin
         fin_in.pitch = sat_dly_ff[DS-1][1] ? PITCH_W'(HALF_PI_Q13) : PITCH_W'(-HALF_PI_Q13);
      end else if (pitch_a > HALF_PI_Q13) begin
         fin_in.pitch = PITCH_W'(HALF_PI_Q13);
      end else if (pitch_a < -HALF_PI_Q13) begin
         fin_in.pitch = PITCH_W'(-HALF_PI_Q13);
      end else begin
         fin_in.pitch = PITCH_W'(pitch_a);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_ff <= fin_in;
      end
   end

   // output register with one skid entry
   rsp_type out_ff, skid_ff;
   logic out_free, produce;

   assign out_free = ~out_vld_ff | rsp_tready;
   assign produce = en & vld_ff[VL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (out_free) begin
            out_vld_ff <= 1'b1;
            skid_vld_ff <= 1'b0;
         end
      end else if (produce) begin
         if (out_free) begin
            out_vld_ff <= 1'b1;
         end else begin
            skid_vld_ff <= 1'b1;
         end
      end else if (out_free) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (out_free) begin
            out_ff <= skid_ff;
         end
      end else if (produce) begin
         if (out_free) begin
            out_ff <= fin_ff;
         end else begin
            skid_ff <= fin_ff;
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = {1'b0, out_ff.yaw, out_ff.pitch, out_ff.roll};
   assign rsp_tuser = out_ff.sat;

   // pitch sits at plus or minus pi/2
   logic pitch_at_limit;

   assign pitch_at_limit = (out_ff.pitch == PITCH_W'(HALF_PI_Q13)) ||
                           (out_ff.pitch == PITCH_W'(-HALF_PI_Q13));

   // checks
   `QTE_ASSERT_IMPLIES(a_skid_needs_out, clock, reset, skid_vld_ff, out_vld_ff)
   `QTE_ASSERT_IMPLIES(a_sat_pitch, clock, reset, out_vld_ff && out_ff.sat, pitch_at_limit)
   `QTE_ASSERT_IMPLIES(a_roll_range, clock, reset, out_vld_ff, out_ff.roll <= PI_Q13 && out_ff.roll >= -PI_Q13)
   `QTE_ASSERT_IMPLIES(a_skid_fill, clock, reset, $rose(skid_vld_ff), $past(out_vld_ff) && !$past(rsp_tready))

endmodule

FILE: verif/quaternion_to_euler_zyx_checker.sv
// checker for quaternion_to_euler_zyx: watches both channels, predicts the euler angles
// of every accepted quaternion and compares them with the rsp items in order
// depends on the block's port list only
module quaternion_to_euler_zyx_checker #(
   parameter int CORDIC_STAGES = 16,
   parameter int COMP_FRAC_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,  // qx[15:0], qy[31:16], qz[47:32], qw[63:48]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,  // roll[15:0], pitch[30:16], yaw[46:31], zero[47]
   input  logic        rsp_tuser,  // pitch_saturated[0]
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint HALF_PI_Q24 = 26353589;
   localparam longint PI_Q13 = 25736;
   localparam longint HALF_PI_Q13 = 12868;

   typedef struct {
      logic [47:0] angles;
      logic        sat;
   } euler_type;

   euler_type euler_queue[$];

   function automatic longint atan_entry(int i);
      longint tab[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
         131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
         16, 8, 4, 2};
      return tab[i];
   endfunction

   // q.28 down to the comparison precision, nearest with ties up
   function automatic longint narrow(longint v);
      int sh;
      sh = 28 - COMP_FRAC_BITS;
      if (sh <= 0) return v <<< (-sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function automatic longint isqrt(longint n);
      longint r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // vectoring-mode arctangent, result in q3.13
   function automatic longint vector_angle(longint y, longint x);
      longint z, t, xs, ys, q;
      int n;
      z = 0;
      if (x == 0 && y == 0) return 0;
      n = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
      // quadrant pre-turn for the left half plane
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = HALF_PI_Q24;
         end else begin
            x = -y; y = t; z = -HALF_PI_Q24;
         end
      end
      for (int i = 0; i < n; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += atan_entry(i);
         end else begin
            x -= ys; y += xs; z -= atan_entry(i);
         end
      end
      q = (z + 1024) >>> 11;
      if (q > PI_Q13) q = PI_Q13;
      if (q < -PI_Q13) q = -PI_Q13;
      return q;
   endfunction

   function automatic euler_type euler_of(logic [63:0] quat);
      longint x, y, z, w, one28, sr, cr, sp, sy, cy, roll, yaw, pitch, s, mag, full, sq;
      euler_type e;
      x = longint'($signed(quat[15:0]));
      y = longint'($signed(quat[31:16]));
      z = longint'($signed(quat[47:32]));
      w = longint'($signed(quat[63:48]));
      one28 = longint'(1) << 28;
      sr = 2 * (w * x + y * z);
      cr = one28 - 2 * (x * x + y * y);
      sp = 2 * (w * y - z * x);
      sy = 2 * (w * z + x * y);
      cy = one28 - 2 * (y * y + z * z);
      roll = vector_angle(narrow(sr), narrow(cr));
      yaw = vector_angle(narrow(sy), narrow(cy));
      e.sat = 1'b0;
      // pitch clamps at |sin| >= 1, else asin via atan2(s, sqrt(1 - s^2))
      if (sp >= one28 || sp <= -one28) begin
         pitch = (sp > 0) ? HALF_PI_Q13 : -HALF_PI_Q13;
         e.sat = 1'b1;
      end else begin
         s = narrow(sp);
         mag = (s < 0) ? -s : s;
         sq = mag * mag;
         full = (longint'(1) << COMP_FRAC_BITS) * (longint'(1) << COMP_FRAC_BITS);
         pitch = vector_angle(s, isqrt(sq >= full ? 0 : full - sq));
         if (pitch > HALF_PI_Q13) pitch = HALF_PI_Q13;
         if (pitch < -HALF_PI_Q13) pitch = -HALF_PI_Q13;
      end
      e.angles = {1'b0, yaw[15:0], pitch[14:0], roll[15:0]};
      return e;
   endfunction

   assign pending = euler_queue.size();

   // predict on req items, compare on rsp items
   always @(posedge clock) begin
      euler_type e;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) euler_queue.push_back(euler_of(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (euler_queue.size() == 0) begin
               $display("%0t: unexpected item, actual angles %h flag %b",
                  $time, rsp_tdata, rsp_tuser);
               fail_count <= fail_count + 1;
            end else begin
               e = euler_queue.pop_front();
               if (e.angles !== rsp_tdata || e.sat !== rsp_tuser) begin
                  $display({"%0t: expected roll %0d pitch %0d yaw %0d flag %b, ",
                     "actual roll %0d pitch %0d yaw %0d flag %b"},
                     $time, $signed(e.angles[15:0]), $signed(e.angles[30:16]),
                     $signed(e.angles[46:31]), e.sat, $signed(rsp_tdata[15:0]),
                     $signed(rsp_tdata[30:16]), $signed(rsp_tdata[46:31]), rsp_tuser);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

FILE: verif/quaternion_to_euler_zyx_tb.sv
// testbench top for quaternion_to_euler_zyx: clock, reset, quaternion stimulus with
// random gaps and rsp stalls, and the verdict; depends on quaternion_to_euler_zyx_checker
module quaternion_to_euler_zyx_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_CYCLES = 5000;
   localparam int DRAIN_CYCLES = 60;
   localparam int RANDOM_ITEMS = 1930;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;  // qx[15:0], qy[31:16], qz[47:32], qw[63:48]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;  // roll[15:0], pitch[30:16], yaw[46:31], zero[47]
   logic        rsp_tuser;  // pitch_saturated[0]
   int          fail_count;
   int          pending;
   int          idle_cycles = 0;
   bit          stim_done = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   quaternion_to_euler_zyx DUT (.*);

   quaternion_to_euler_zyx_checker checker_i (.*);

   // quaternion of random direction, rough unit norm, sometimes perturbed
   function automatic logic [63:0] random_quat();
      int c[4];
      int mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 4; i++) begin
         if (mode == 0) c[i] = $urandom_range(0, 65535) - 32768;
         else if (mode == 1) c[i] = $urandom_range(0, 32768) - 16384;
         else c[i] = $urandom_range(0, 23170) - 11585;
      end
      // near gimbal lock: w*y - z*x close to one half
      if (mode == 2) begin
         c[1] = ($urandom_range(0, 1) ? 11585 : -11585) + $urandom_range(0, 40) - 20;
         c[3] = (c[1] > 0 ? 11585 : -11585) + $urandom_range(0, 40) - 20;
         c[0] = $urandom_range(0, 60) - 30;
         c[2] = $urandom_range(0, 60) - 30;
      end
      return {c[3][15:0], c[2][15:0], c[1][15:0], c[0][15:0]};
   endfunction

   // req side may hold req_tvalid low for a random gap before each item
   task automatic send(logic [63:0] quat);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= quat;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // rsp side may hold rsp_tready low for a random gap before taking each item
   initial begin
      int gap;
      wait (!reset);
      @(negedge clock);
      forever begin
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   // watchdog on cycles without any accepted item while items remain to send or check
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (stim_done && pending == 0)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("quaternion_to_euler_zyx: mismatch");
            $finish;
         end
      end
   end

   initial begin
      logic [63:0] directed[$];
      int n;
      directed = '{
         64'h4000_0000_0000_0000, 64'hC000_0000_0000_0000, 64'h0000_4000_0000_0000,
         64'h0000_0000_4000_0000, 64'h0000_0000_0000_4000, 64'h0000_0000_0000_0000,
         64'h2D41_0000_2D41_0000, 64'h2D41_0000_D2BF_0000, 64'h2D41_2D41_0000_0000,
         64'h2000_2000_2000_2000, 64'hE000_2000_E000_2000, 64'h7FFF_7FFF_7FFF_7FFF,
         64'h8000_8000_8000_8000, 64'h8000_7FFF_8000_7FFF, 64'hFFFF_FFFF_FFFF_FFFF,
         64'h0001_0000_0001_0000, 64'hC000_C000_C000_C000, 64'h4000_4000_4000_4000,
         64'h0000_0000_0001_0000, 64'h0000_0000_FFFF_0000, 64'h5555_AAAA_5555_AAAA,
         64'hAAAA_5555_AAAA_5555, 64'h2D42_0000_2D41_0000};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send(directed[i]);
      n = 0;
      while (n < RANDOM_ITEMS) begin
         send(random_quat());
         n++;
         // a run without gaps now and then
         if ($urandom_range(0, 30) == 0) begin
            for (int k = 0; k < 20; k++) begin
               req_tdata <= random_quat();
               req_tvalid <= 1'b1;
               do @(posedge clock); while (!req_tready);
               @(negedge clock);
            end
            n += 20;
         end
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("quaternion_to_euler_zyx: match");
      else $display("quaternion_to_euler_zyx: mismatch");
      $finish;
   end
endmodule
